@@ sv/bba_pkg.sv @@
package bba_pkg;

    // sizing
    localparam int MAX_BLOCKS = 1024;
    localparam int MAX_RUN    = 64;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int ROW_BITS   = 32;
    localparam int ROW_W      = $clog2(ROW_BITS);
    localparam int ROWS       = MAX_BLOCKS / ROW_BITS;
    localparam int ROW_AW     = BLK_W - ROW_W;
    localparam int CNT_W      = BLK_W + 1;
    localparam int RUN_SH     = $clog2(MAX_RUN);

    // divider operand widths
    localparam int DIV_N_W    = BLK_W;
    localparam int DIV_D_W    = 15;
    localparam int DIV_C_W    = $clog2(DIV_N_W + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BSIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WBITS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 3'd4;

    // opcodes and result codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BAD_FREE  = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [15:0] request_size_k;
        logic [9:0]  free_block;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  block_number;
        logic [9:0]  word_index;
        logic [5:0]  bit_index;
        logic [9:0]  cylinder;
        logic [5:0]  head;
        logic [7:0]  sector;
        logic [10:0] free_count;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        DIV_WORD,
        DIV_CYL,
        DIV_HEAD
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_TEST,
        S_ERR,
        S_DW_GO,
        S_DW_WAIT,
        S_DC_GO,
        S_DC_WAIT,
        S_DH_GO,
        S_DH_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     rd_row;
        logic     set_bit;
        logic     clr_bit;
        logic     adv;
        logic     div_start;
        logic     div_cap;
        div_sel_t div_sel;
        logic     emit_ok;
        logic     emit_err;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic alloc_err;
        logic free_bad;
        logic bit_used;
        logic div_done;
        logic last;
        logic out_free;
    } sts_t;

    // effective register values
    function automatic logic [10:0] eff_total(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0)
            r = 11'd1;
        else if (v > 11'(MAX_BLOCKS))
            r = 11'(MAX_BLOCKS);
        return r;
    endfunction

    function automatic logic [6:0] eff_64(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0)
            r = 7'd1;
        else if (v > 7'd64)
            r = 7'd64;
        return r;
    endfunction

    function automatic logic [6:0] eff_nz(input logic [6:0] v);
        return (v == 7'd0) ? 7'd1 : v;
    endfunction

    function automatic logic [8:0] eff_sp(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v == 9'd0)
            r = 9'd1;
        else if (v > 9'd256)
            r = 9'd256;
        return r;
    endfunction

endpackage

@@ sv/bba_div.sv @@
module bba_div
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic [DIV_N_W-1:0] quo,
    output logic [DIV_D_W-1:0] rem,
    output logic               done
);

    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic               busy_reg, done_reg;
    logic [DIV_D_W:0]   trial;

    // one restoring step per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_N_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = DIV_D_W'(trial - {1'b0, den_reg});
            quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_C_W'(DIV_N_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

@@ sv/bba_dp.sv @@
module bba_dp
    import bba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  in_item_t              in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    // configuration and counters
    logic [10:0] tot_reg;
    logic [6:0]  bs_reg, wb_reg, hd_reg;
    logic [8:0]  sp_reg;
    logic [CNT_W-1:0] free_cnt_reg;
    logic [ROWS-1:0]  row_vld_reg;

    // item state
    logic              op_reg, last_reg;
    logic [15:0]       remain_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [17:0]       cap_reg;
    logic [DIV_D_W-1:0] cyl_reg;

    // location fields
    logic [9:0] word_reg, cylq_reg, remc_reg;
    logic [5:0] bitx_reg, head_reg;
    logic [7:0] sect_reg;

    // bitmap memory
    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg, wdata, mask;
    logic [ROW_AW-1:0]   row_addr;
    logic                wr_en;

    // output register
    out_item_t out_reg;
    logic      out_vld_reg;

    // effective values
    logic [10:0] tot_eff;
    logic [6:0]  bs_eff, wb_eff, hd_eff;
    logic [8:0]  sp_eff;
    logic        empty, no_space, too_large;
    logic [2:0]  err_code;

    // divider
    logic [DIV_N_W-1:0] div_num, div_quo;
    logic [DIV_D_W-1:0] div_den, div_rem;
    logic               div_done;

    assign tot_eff = eff_total(tot_reg);
    assign bs_eff  = eff_nz(bs_reg);
    assign wb_eff  = eff_64(wb_reg);
    assign hd_eff  = eff_64(hd_reg);
    assign sp_eff  = eff_sp(sp_reg);

    // configuration registers and free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg      <= 11'(MAX_BLOCKS);
            bs_reg       <= 7'd1;
            wb_reg       <= 7'd32;
            hd_reg       <= 7'd4;
            sp_reg       <= 9'd8;
            free_cnt_reg <= CNT_W'(MAX_BLOCKS);
            row_vld_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL:
                    begin
                        tot_reg      <= cfg_data;
                        free_cnt_reg <= CNT_W'(eff_total(cfg_data));
                        row_vld_reg  <= '0;
                    end
                    CFG_BSIZE:   bs_reg <= cfg_data[6:0];
                    CFG_WBITS:   wb_reg <= cfg_data[6:0];
                    CFG_HEADS:   hd_reg <= cfg_data[6:0];
                    CFG_SECTORS: sp_reg <= cfg_data[8:0];
                    default:     ;
                endcase
            end
            else
            begin
                if (cmd.set_bit)
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                else if (cmd.clr_bit)
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                if (wr_en)
                    row_vld_reg[row_addr] <= 1'b1;
            end
        end
    end

    // capacity and cylinder size, registered from their operands
    always_ff @(posedge clk)
    begin
        cap_reg <= 18'(free_cnt_reg) * 18'(bs_eff);
        cyl_reg <= DIV_D_W'(hd_eff) * DIV_D_W'(sp_eff);
    end

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_data.opcode;
            remain_reg <= in_data.request_size_k;
            blk_reg    <= (in_data.opcode == OP_FREE) ? in_data.free_block : '0;
            last_reg   <= (in_data.opcode == OP_FREE);
        end
        else
        begin
            if (cmd.adv)
                blk_reg <= blk_reg + 1'b1;
            if (cmd.set_bit)
            begin
                last_reg   <= (remain_reg <= 16'(bs_eff));
                remain_reg <= remain_reg - 16'(bs_eff);
            end
        end
    end

    // bitmap row access
    assign row_addr = blk_reg[BLK_W-1:ROW_W];
    assign mask     = ROW_BITS'(1) << blk_reg[ROW_W-1:0];
    assign wr_en    = cmd.set_bit | cmd.clr_bit;
    assign wdata    = cmd.set_bit ? (rdata_reg | mask) : (rdata_reg & ~mask);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[row_addr] <= wdata;
            rdata_reg     <= wdata;
        end
        else if (cmd.rd_row)
        begin
            rdata_reg <= row_vld_reg[row_addr] ? mem[row_addr] : '0;
        end
    end

    // request checks
    assign empty     = (remain_reg == 16'd0);
    assign no_space  = ({2'b0, remain_reg} > cap_reg);
    assign too_large = (remain_reg > 16'({bs_eff, RUN_SH'(0)}));

    always_comb
    begin
        if (op_reg == OP_FREE)
            err_code = ST_BAD_FREE;
        else if (empty)
            err_code = ST_EMPTY;
        else if (no_space)
            err_code = ST_NO_SPACE;
        else
            err_code = ST_TOO_LARGE;
    end

    // divider operand selection
    always_comb
    begin
        case (cmd.div_sel)
            DIV_WORD:
            begin
                div_num = blk_reg;
                div_den = DIV_D_W'(wb_eff);
            end
            DIV_CYL:
            begin
                div_num = blk_reg;
                div_den = cyl_reg;
            end
            DIV_HEAD:
            begin
                div_num = remc_reg;
                div_den = DIV_D_W'(sp_eff);
            end
            default:
            begin
                div_num = blk_reg;
                div_den = DIV_D_W'(wb_eff);
            end
        endcase
    end

    bba_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    // capture quotient and remainder
    always_ff @(posedge clk)
    begin
        if (cmd.div_cap)
        begin
            case (cmd.div_sel)
                DIV_WORD:
                begin
                    word_reg <= div_quo;
                    bitx_reg <= div_rem[5:0];
                end
                DIV_CYL:
                begin
                    cylq_reg <= div_quo;
                    remc_reg <= div_rem[9:0];
                end
                DIV_HEAD:
                begin
                    head_reg <= div_quo[5:0];
                    sect_reg <= div_rem[7:0];
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.emit_ok || cmd.emit_err)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ok)
        begin
            out_reg.status       <= ST_OK;
            out_reg.block_number <= blk_reg;
            out_reg.word_index   <= word_reg;
            out_reg.bit_index    <= bitx_reg;
            out_reg.cylinder     <= cylq_reg;
            out_reg.head         <= head_reg;
            out_reg.sector       <= sect_reg;
            out_reg.free_count   <= free_cnt_reg;
            out_reg.last         <= last_reg;
        end
        else if (cmd.emit_err)
        begin
            out_reg.status       <= err_code;
            out_reg.block_number <= (op_reg == OP_FREE) ? blk_reg : '0;
            out_reg.word_index   <= '0;
            out_reg.bit_index    <= '0;
            out_reg.cylinder     <= '0;
            out_reg.head         <= '0;
            out_reg.sector       <= '0;
            out_reg.free_count   <= free_cnt_reg;
            out_reg.last         <= 1'b1;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // status to the controller
    assign sts.is_free   = (op_reg == OP_FREE);
    assign sts.alloc_err = empty | no_space | too_large;
    assign sts.bit_used  = rdata_reg[blk_reg[ROW_W-1:0]];
    assign sts.free_bad  = ({1'b0, blk_reg} >= tot_eff) | ~rdata_reg[blk_reg[ROW_W-1:0]];
    assign sts.div_done  = div_done;
    assign sts.last      = last_reg;
    assign sts.out_free  = ~out_vld_reg | ~out_stall;

endmodule

@@ sv/bba_ctrl.sv @@
module bba_ctrl
    import bba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CHECK;
            S_CHECK:
                if (!sts.is_free && sts.alloc_err)
                    state_next = S_ERR;
                else
                    state_next = S_RD;
            S_RD:
                state_next = S_TEST;
            S_TEST:
                if (sts.is_free)
                    state_next = sts.free_bad ? S_ERR : S_DW_GO;
                else
                    state_next = sts.bit_used ? S_RD : S_DW_GO;
            S_ERR:
                if (sts.out_free)
                    state_next = S_IDLE;
            S_DW_GO:
                state_next = S_DW_WAIT;
            S_DW_WAIT:
                if (sts.div_done)
                    state_next = S_DC_GO;
            S_DC_GO:
                state_next = S_DC_WAIT;
            S_DC_WAIT:
                if (sts.div_done)
                    state_next = S_DH_GO;
            S_DH_GO:
                state_next = S_DH_WAIT;
            S_DH_WAIT:
                if (sts.div_done)
                    state_next = S_EMIT;
            S_EMIT:
                if (sts.out_free)
                    state_next = sts.last ? S_IDLE : S_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DIV_WORD;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_RD:
                cmd.rd_row = 1'b1;
            S_TEST:
                if (sts.is_free)
                    cmd.clr_bit = ~sts.free_bad;
                else if (sts.bit_used)
                    cmd.adv = 1'b1;
                else
                    cmd.set_bit = 1'b1;
            S_ERR:
                cmd.emit_err = sts.out_free;
            S_DW_GO:
                cmd.div_start = 1'b1;
            S_DW_WAIT:
                cmd.div_cap = sts.div_done;
            S_DC_GO:
            begin
                cmd.div_sel   = DIV_CYL;
                cmd.div_start = 1'b1;
            end
            S_DC_WAIT:
            begin
                cmd.div_sel = DIV_CYL;
                cmd.div_cap = sts.div_done;
            end
            S_DH_GO:
            begin
                cmd.div_sel   = DIV_HEAD;
                cmd.div_start = 1'b1;
            end
            S_DH_WAIT:
            begin
                cmd.div_sel = DIV_HEAD;
                cmd.div_cap = sts.div_done;
            end
            S_EMIT:
            begin
                cmd.emit_ok = sts.out_free;
                cmd.adv     = sts.out_free & ~sts.last;
            end
            default: ;
        endcase
    end

endmodule

@@ sv/bitmap_block_allocator_unit.sv @@
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   in_data    (in_item_t)
// out       out  out_valid/out_stall out_data   (out_item_t)
// cfg       in   cfg_we              cfg_index, cfg_data
//
// one item at a time; a free tests its bit and clears it, an allocate reads the
// row of each block from block zero, skips used blocks and sets one per block handed out
// each result is located by the shared 10-step divider run three times (word,
// cylinder, head); a rejected request and a bad free give one error result
// reset (and a total_blocks write) clears the bitmap at once via row valid bits
// out_stall only holds the result register; the next result waits behind it
module bitmap_block_allocator_unit
    import bba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign in_stall = ~in_ready;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // when idle, any waiting result closes its item
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!out_valid || out_data.last))
        else $error("idle with an unfinished item");

    // every error result is the last one
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |-> out_data.last)
        else $error("error result not last");

    // rejected allocations carry no block
    a_err_blk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK && out_data.status != ST_BAD_FREE)
            |-> (out_data.block_number == '0 && out_data.word_index == '0))
        else $error("rejected allocation carries a location");

endmodule

@@ verif/bitmap_block_allocator_unit_chk.sv @@
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_chk
    import bba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    results_seen
);

    // shadow of the disk state and the numbering registers
    bit          used_map [MAX_BLOCKS];
    int unsigned free_left;
    logic [10:0] total_reg;
    logic [6:0]  bsize_reg;
    logic [6:0]  wbits_reg;
    logic [6:0]  heads_reg;
    logic [8:0]  spt_reg;

    out_item_t   expected_q [$];

    assign pending = expected_q.size();

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // result for a block with its position on the disk
    function automatic out_item_t locate(int unsigned blk, logic [2:0] st, logic fin);
        int unsigned wb;
        int unsigned sp;
        int unsigned cyl;
        out_item_t   r;
        wb  = clip(wbits_reg, 64);
        sp  = clip(spt_reg, 256);
        cyl = clip(heads_reg, 64) * sp;
        r.status       = st;
        r.block_number = 10'(blk);
        r.word_index   = 10'(blk / wb);
        r.bit_index    = 6'(blk % wb);
        r.cylinder     = 10'(blk / cyl);
        r.head         = 6'((blk % cyl) / sp);
        r.sector       = 8'((blk % cyl) % sp);
        r.free_count   = 11'(free_left);
        r.last         = fin;
        return r;
    endfunction

    // single result for a rejected request, location left at zero
    function automatic out_item_t refusal(logic [2:0] st, int unsigned blk);
        out_item_t r;
        r              = '0;
        r.status       = st;
        r.block_number = 10'(blk);
        r.free_count   = 11'(free_left);
        r.last         = 1'b1;
        return r;
    endfunction

    task automatic clear_disk();
        foreach (used_map[i])
            used_map[i] = 1'b0;
        free_left = clip(total_reg, MAX_BLOCKS);
    endtask

    // work out the results of one request and queue them
    task automatic plan_request(in_item_t req);
        int unsigned disk;
        int unsigned bs;
        int unsigned size;
        int unsigned need;
        int unsigned got;
        disk = clip(total_reg, MAX_BLOCKS);
        if (req.opcode == OP_FREE) begin
            if (req.free_block >= disk || !used_map[req.free_block]) begin
                expected_q.push_back(refusal(ST_BAD_FREE, req.free_block));
            end
            else begin
                used_map[req.free_block] = 1'b0;
                free_left++;
                expected_q.push_back(locate(req.free_block, ST_OK, 1'b1));
            end
        end
        else begin
            bs   = clip(bsize_reg, 127);
            size = req.request_size_k;
            need = (size + bs - 1) / bs;
            if (size == 0)
                expected_q.push_back(refusal(ST_EMPTY, 0));
            else if (size > free_left * bs)
                expected_q.push_back(refusal(ST_NO_SPACE, 0));
            else if (need > MAX_RUN)
                expected_q.push_back(refusal(ST_TOO_LARGE, 0));
            else begin
                // first fit from block zero
                got = 0;
                for (int unsigned b = 0; b < disk && got < need; b++) begin
                    if (!used_map[b]) begin
                        used_map[b] = 1'b1;
                        free_left--;
                        got++;
                        expected_q.push_back(locate(b, ST_OK, got == need));
                    end
                end
            end
        end
    endtask

    task automatic compare_result(out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
        end
        if (got.block_number !== want.block_number) begin
            $error("block_number expected %0d actual %0d", want.block_number,
                   got.block_number);
            errors++;
        end
        if (got.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index, got.word_index);
            errors++;
        end
        if (got.bit_index !== want.bit_index) begin
            $error("bit_index expected %0d actual %0d", want.bit_index, got.bit_index);
            errors++;
        end
        if (got.cylinder !== want.cylinder) begin
            $error("cylinder expected %0d actual %0d", want.cylinder, got.cylinder);
            errors++;
        end
        if (got.head !== want.head) begin
            $error("head expected %0d actual %0d", want.head, got.head);
            errors++;
        end
        if (got.sector !== want.sector) begin
            $error("sector expected %0d actual %0d", want.sector, got.sector);
            errors++;
        end
        if (got.free_count !== want.free_count) begin
            $error("free_count expected %0d actual %0d", want.free_count, got.free_count);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
        end
    endtask

    // watch register writes and both channels
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg    = 11'd1024;
            bsize_reg    = 7'd1;
            wbits_reg    = 7'd32;
            heads_reg    = 7'd4;
            spt_reg      = 9'd8;
            errors       = 0;
            results_seen = 0;
            expected_q.delete();
            clear_disk();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TOTAL:
                    begin
                        total_reg = cfg_data[10:0];
                        clear_disk();
                    end
                    CFG_BSIZE:   bsize_reg = cfg_data[6:0];
                    CFG_WBITS:   wbits_reg = cfg_data[6:0];
                    CFG_HEADS:   heads_reg = cfg_data[6:0];
                    CFG_SECTORS: spt_reg   = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                compare_result(out_data);
            end
            if (in_valid && !in_stall)
                plan_request(in_data);
        end
    end

endmodule

@@ verif/bitmap_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int PHASES      = 7;
    localparam int PER_PHASE   = 36;
    localparam int IN_W        = $bits(in_item_t);

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  errors;
    int  pending;
    int  results_seen;
    int  cycles;
    int  requests_sent;
    int  settings_used;
    bit  hold_go;
    bit  sender_calm;
    int  hold_left;

    // disk size and block size as last written, for shaping requests
    int unsigned disk_blocks;
    int unsigned blk_k;

    bitmap_block_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bitmap_block_allocator_unit_chk chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: random stalls, a quiet window, and one long hold on request
    initial
    begin
        bit hold_used;
        hold_used = 1'b0;
        out_stall = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_used) begin
                hold_left = 700;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (cycles > 30000 && cycles < 90000)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 17);
        end
    end

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
    endtask

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // wait until every result is in and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic configure(int unsigned tot, int unsigned bs, int unsigned wb,
                             int unsigned hd, int unsigned sp);
        drain();
        put_reg(CFG_TOTAL, tot);
        put_reg(CFG_BSIZE, bs);
        put_reg(CFG_WBITS, wb);
        put_reg(CFG_HEADS, hd);
        put_reg(CFG_SECTORS, sp);
        cfg_we <= 1'b0;
        disk_blocks = clip(tot & 11'h7FF, MAX_BLOCKS);
        blk_k       = clip(bs & 7'h7F, 127);
        settings_used++;
    endtask

    // offer one request and hold it until the transfer
    task automatic send(in_item_t req);
        if (!sender_calm && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic in_item_t make_alloc(int unsigned size);
        in_item_t r;
        r                = in_item_t'(IN_W'($urandom));
        r.opcode         = OP_ALLOC;
        r.request_size_k = 16'(size);
        return r;
    endfunction

    function automatic in_item_t make_free(int unsigned blk);
        in_item_t r;
        r            = in_item_t'(IN_W'($urandom));
        r.opcode     = OP_FREE;
        r.free_block = 10'(blk);
        return r;
    endfunction

    // random request, weighted towards sequences that fill and punch holes
    function automatic in_item_t random_request();
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = (disk_blocks < 150) ? disk_blocks : 150;
        if (pick < 45)
            return make_alloc($urandom_range(1, blk_k * 6));
        else if (pick < 53)
            return make_alloc($urandom_range(blk_k * 62, blk_k * 66));
        else if (pick < 58)
            return make_alloc($urandom_range(65535));
        else if (pick < 61)
            return make_alloc(0);
        else if (pick < 90)
            return make_free($urandom_range(span + 3) % MAX_BLOCKS);
        else
            return make_free($urandom_range(1023));
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_go       = 1'b0;
        sender_calm   = 1'b0;
        requests_sent = 0;
        settings_used = 1;
        disk_blocks   = 1024;
        blk_k         = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed checks on the reset numbering
        send(make_alloc(0));
        send(make_alloc(65535));
        send(make_alloc(65));
        send(make_alloc(64));
        send(make_alloc(1));
        send(make_alloc(3));
        send(make_free(1023));
        send(make_free(5));
        send(make_free(5));
        send(make_alloc(2));
        send(make_free(0));
        send(make_free(64));
        send(make_alloc(1));
        send(in_item_t'({1'b1, 16'hFFFF, 10'h3FF}));
        send(in_item_t'({1'b0, 16'h0001, 10'h3FF}));
        send(make_free(1));

        // tiny disk: out of range frees and no space
        configure(3, 2, 1, 1, 1);
        send(make_alloc(7));
        send(make_alloc(6));
        send(make_free(3));
        send(make_free(2));
        send(make_alloc(3));
        send(make_alloc(1));

        // random phases across register settings, extremes included
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(1024, 1, 32, 4, 8);
                1: configure(0, 0, 0, 0, 0);
                2: configure(2047, 127, 127, 127, 511);
                3: configure(48, 2, 64, 64, 256);
                4: configure(1024, 1, 1, 1, 1);
                5: configure(100, 3, 7, 3, 5);
                default: configure($urandom_range(1, 2047), $urandom_range(127),
                                   $urandom_range(127), $urandom_range(127),
                                   $urandom_range(511));
            endcase
            sender_calm = (ph == 4);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 0 && n == 8)
                    hold_go = 1'b1;
                if (ph == 0 && n == 14)
                    hold_go = 1'b0;
                if (ph == 2 && n == 18)
                    drain();
                send(random_request());
            end
        end

        drain();
        $display("%0d requests over %0d register settings, %0d results checked",
                 requests_sent, settings_used, results_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
sv/bba_pkg.sv
sv/bba_div.sv
sv/bba_dp.sv
sv/bba_ctrl.sv
sv/bitmap_block_allocator_unit.sv
verif/bitmap_block_allocator_unit_chk.sv
verif/bitmap_block_allocator_unit_tb.sv
